// ----- rtl/vmea_pkg.sv -----
// Shared types and constants for the effective address unit.
package vmea_pkg;

    // Bytes in one instruction or extension word.
    localparam logic [31:0] WORD_BYTES = 32'd4;
    localparam logic [2:0]  WORD_SIZE  = 3'd4;

    // Action codes of an input item.
    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_EVAL  = 1'b1;

    // Configuration register indexes.
    localparam logic [1:0] CFG_DATA_BASE  = 2'd0;
    localparam logic [1:0] CFG_CONST_BASE = 2'd1;
    localparam logic [1:0] CFG_BIG_ENDIAN = 2'd2;

    // Addressing modes; codes above MODE_PC are unused.
    typedef enum logic [3:0] {
        MODE_DIRECT      = 4'd0,
        MODE_IND         = 4'd1,
        MODE_IND_OFF     = 4'd2,
        MODE_IND_OFF_UPD = 4'd3,
        MODE_IDX         = 4'd4,
        MODE_IDX_UPD     = 4'd5,
        MODE_SCALED      = 4'd6,
        MODE_SCALED_UPD  = 4'd7,
        MODE_CTR         = 4'd8,
        MODE_DATA        = 4'd9,
        MODE_CONST       = 4'd10,
        MODE_LIT         = 4'd11,
        MODE_PC          = 4'd12
    } t_mode;

    // Result kinds.
    typedef enum logic [1:0] {
        KIND_REG   = 2'd0,
        KIND_MEM   = 2'd1,
        KIND_CTR   = 2'd2,
        KIND_WRITE = 2'd3
    } t_kind;

    // One input item.
    typedef struct packed {
        logic        action;
        logic [3:0]  mode;
        logic [4:0]  reg_sel;
        logic [31:0] ext_word;
        logic [31:0] inst_addr;
        logic [2:0]  operand_size;
        logic [31:0] write_value;
    } t_ea_req;

    // One result item.
    typedef struct packed {
        logic [1:0]  result_kind;
        logic [31:0] address;
        logic [4:0]  operand_reg;
        logic [31:0] next_inst_addr;
        logic        base_updated;
    } t_ea_rsp;

endpackage

// ----- rtl/vmea_req_if.sv -----
// Request channel: valid/ready handshake with the input item fields.
interface vmea_req_if;
    logic        valid;
    logic        ready;
    logic        action;
    logic [3:0]  mode;
    logic [4:0]  reg_sel;
    logic [31:0] ext_word;
    logic [31:0] inst_addr;
    logic [2:0]  operand_size;
    logic [31:0] write_value;

    modport source (
        output valid, action, mode, reg_sel, ext_word, inst_addr, operand_size,
               write_value,
        input  ready
    );

    modport sink (
        input  valid, action, mode, reg_sel, ext_word, inst_addr, operand_size,
               write_value,
        output ready
    );
endinterface

// ----- rtl/vmea_rsp_if.sv -----
// Response channel: valid/ready handshake with the result item fields.
interface vmea_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  result_kind;
    logic [31:0] address;
    logic [4:0]  operand_reg;
    logic [31:0] next_inst_addr;
    logic        base_updated;

    modport source (
        output valid, result_kind, address, operand_reg, next_inst_addr,
               base_updated,
        input  ready
    );

    modport sink (
        input  valid, result_kind, address, operand_reg, next_inst_addr,
               base_updated,
        output ready
    );
endinterface

// ----- rtl/vmea_regfile.sv -----
// Register file: synchronous memory with two read ports, one write port and
// per-entry valid bits so that unwritten entries read as zero after reset.
module vmea_regfile #(
    parameter int NUM_REGS = 32,
    parameter int IDX_W    = 5
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_rd_en,
    input  logic [IDX_W-1:0] i_rd_idx_a,
    input  logic [IDX_W-1:0] i_rd_idx_b,
    output logic [31:0]      o_rd_data_a,
    output logic [31:0]      o_rd_data_b,
    input  logic             i_wr_en,
    input  logic [IDX_W-1:0] i_wr_idx,
    input  logic [31:0]      i_wr_data
);

    logic [31:0]         r_mem [NUM_REGS];
    logic [NUM_REGS-1:0] r_vld;
    logic [31:0]         r_rd_a;
    logic [31:0]         r_rd_b;
    logic                r_rd_vld_a;
    logic                r_rd_vld_b;

    // Memory array: write port and registered read ports.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_idx] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_a <= r_mem[i_rd_idx_a];
            r_rd_b <= r_mem[i_rd_idx_b];
        end
    end

    // Valid bits: cleared by reset, set by the first write of an entry.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld      <= '0;
            r_rd_vld_a <= 1'b0;
            r_rd_vld_b <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_vld[i_wr_idx] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_vld_a <= r_vld[i_rd_idx_a];
                r_rd_vld_b <= r_vld[i_rd_idx_b];
            end
        end
    end

    // An entry never written since reset reads as zero.
    assign o_rd_data_a = r_rd_vld_a ? r_rd_a : 32'd0;
    assign o_rd_data_b = r_rd_vld_b ? r_rd_b : 32'd0;

endmodule

// ----- rtl/vmea_calc.sv -----
// Address calculation: decodes the mode and forms the result item from the
// register file read data and the configuration registers.
module vmea_calc #(
    parameter int ADDR_BITS = 32
) (
    input  vmea_pkg::t_ea_req i_req,
    input  logic [31:0]       i_rd_data_a,
    input  logic [31:0]       i_rd_data_b,
    input  logic [4:0]        i_operand_reg,
    input  logic [31:0]       i_data_base,
    input  logic [31:0]       i_const_base,
    input  logic              i_big_endian,
    output vmea_pkg::t_ea_rsp o_rsp
);
    import vmea_pkg::*;

    // Address wrap mask; wider address spaces still land in a 32-bit field.
    localparam logic [31:0] ADDR_MASK =
        (ADDR_BITS >= 32) ? 32'hFFFF_FFFF : 32'((64'd1 << ADDR_BITS) - 64'd1);

    logic [31:0] ia4;
    logic [31:0] prod;
    logic [31:0] addr;
    logic [31:0] next_addr;
    logic [2:0]  lit_size;
    logic [31:0] lit_pad;
    logic        upd;
    logic [1:0]  kind;
    logic [4:0]  opreg;

    // Word after the opcode, scaled index and literal placement.
    always_comb begin
        ia4      = i_req.inst_addr + WORD_BYTES;
        prod     = i_rd_data_b * 32'(i_req.ext_word[31:16]);
        lit_size = ((i_req.operand_size == 3'd0) || (i_req.operand_size > WORD_SIZE))
                   ? WORD_SIZE : i_req.operand_size;
        lit_pad  = i_big_endian ? 32'(WORD_SIZE - lit_size) : 32'd0;
    end

    // Mode decode.
    always_comb begin
        kind      = KIND_MEM;
        addr      = 32'd0;
        next_addr = i_req.inst_addr;
        upd       = 1'b0;
        opreg     = 5'd0;
        unique case (t_mode'(i_req.mode)) inside
            MODE_DIRECT: begin
                kind  = KIND_REG;
                opreg = i_operand_reg;
            end
            MODE_IND: begin
                addr = i_rd_data_a;
            end
            MODE_IND_OFF, MODE_IND_OFF_UPD: begin
                addr      = i_rd_data_a + i_req.ext_word;
                next_addr = ia4;
                upd       = (i_req.mode == MODE_IND_OFF_UPD);
            end
            MODE_IDX, MODE_IDX_UPD: begin
                addr      = i_rd_data_a + i_rd_data_b;
                next_addr = ia4;
                upd       = (i_req.mode == MODE_IDX_UPD);
            end
            MODE_SCALED, MODE_SCALED_UPD: begin
                addr      = i_rd_data_a + prod;
                next_addr = ia4;
                upd       = (i_req.mode == MODE_SCALED_UPD);
            end
            MODE_CTR: begin
                kind = KIND_CTR;
            end
            MODE_DATA: begin
                addr      = i_data_base + i_req.ext_word;
                next_addr = ia4;
            end
            MODE_CONST: begin
                addr      = i_const_base + i_req.ext_word;
                next_addr = ia4;
            end
            MODE_LIT: begin
                addr      = ia4 + lit_pad;
                next_addr = ia4;
            end
            MODE_PC: begin
                addr      = ia4 + {i_req.ext_word[29:0], 2'b00};
                next_addr = ia4;
            end
            default: begin
                // Unused mode codes: memory kind at address zero.
                addr = 32'd0;
            end
        endcase
    end

    // Result item; a register write reports only its kind.
    always_comb begin
        if (i_req.action == ACT_WRITE) begin
            o_rsp             = '0;
            o_rsp.result_kind = KIND_WRITE;
        end else begin
            o_rsp.result_kind    = kind;
            o_rsp.address        = addr & ADDR_MASK;
            o_rsp.operand_reg    = opreg;
            o_rsp.next_inst_addr = next_addr & ADDR_MASK;
            o_rsp.base_updated   = upd;
        end
    end

endmodule

// ----- rtl/vm_effective_address_unit_core.sv -----
// Effective address unit top level: handshake control, configuration and
// register file read-modify-write.
//
//   Channel   Direction  Handshake       Carries
//   i_req     in         valid / ready   action, mode, reg_sel, ext_word, ...
//   o_rsp     out        valid / ready   result_kind, address, next_inst_addr
//   i_cfg_*   in         write enable    data_base, const_base, big_endian
//
// An item is handled in order: the register file read at the accepting edge,
// then address calculation and base write-back while r_busy is set, which also
// loads the output register. No new item is taken while r_busy is set, so an
// item is taken only once the last one is calculated and the output is free or draining.
// Reset clears the register file valid bits at once; no clearing pass.
// A stalled output register holds off the next item.
module vm_effective_address_unit_core #(
    parameter int NUM_REGS  = 32,
    parameter int ADDR_BITS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    vmea_req_if.sink    i_req,
    vmea_rsp_if.source  o_rsp,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_wdata
);
    import vmea_pkg::*;

    localparam int IDX_W = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;

    // Register number reduction table for 8-bit selectors.
    typedef logic [IDX_W-1:0] t_mod_tbl [256];

    function automatic t_mod_tbl f_mod_tbl();
        t_mod_tbl tbl;
        for (int i = 0; i < 256; i++) begin
            tbl[i] = IDX_W'(i % NUM_REGS);
        end
        return tbl;
    endfunction

    localparam t_mod_tbl MOD_TBL = f_mod_tbl();

    logic             acc;
    logic             r_busy;
    logic             r_out_vld;
    t_ea_req          r_req;
    t_ea_rsp          r_rsp;
    t_ea_rsp          calc_rsp;
    logic [IDX_W-1:0] r_rsel;
    logic [IDX_W-1:0] r_bidx;
    logic [31:0]      r_data_base;
    logic [31:0]      r_const_base;
    logic             r_big_endian;
    logic [IDX_W-1:0] in_rsel;
    logic [IDX_W-1:0] in_bidx;
    logic [IDX_W-1:0] in_xidx;
    logic [IDX_W-1:0] rd_idx_a;
    logic             in_indexed;
    logic [31:0]      rd_data_a;
    logic [31:0]      rd_data_b;
    logic             wr_en;
    logic [IDX_W-1:0] wr_idx;
    logic [31:0]      wr_data;

    // Input handshake: one item in flight, output register free or draining.
    assign i_req.ready = !r_busy && (!r_out_vld || o_rsp.ready);
    assign acc         = i_req.valid && i_req.ready;

    // Register selectors reduced to the register file depth.
    always_comb begin
        in_rsel    = MOD_TBL[{3'b000, i_req.reg_sel}];
        in_bidx    = MOD_TBL[i_req.ext_word[7:0]];
        in_xidx    = MOD_TBL[i_req.ext_word[15:8]];
        in_indexed = (i_req.mode == MODE_IDX) || (i_req.mode == MODE_IDX_UPD) ||
                     (i_req.mode == MODE_SCALED) || (i_req.mode == MODE_SCALED_UPD);
        rd_idx_a   = in_indexed ? in_bidx : in_rsel;
    end

    vmea_regfile #(
        .NUM_REGS (NUM_REGS),
        .IDX_W    (IDX_W)
    ) u_regfile (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rd_en     (acc),
        .i_rd_idx_a  (rd_idx_a),
        .i_rd_idx_b  (in_xidx),
        .o_rd_data_a (rd_data_a),
        .o_rd_data_b (rd_data_b),
        .i_wr_en     (wr_en),
        .i_wr_idx    (wr_idx),
        .i_wr_data   (wr_data)
    );

    vmea_calc #(
        .ADDR_BITS (ADDR_BITS)
    ) u_calc (
        .i_req         (r_req),
        .i_rd_data_a   (rd_data_a),
        .i_rd_data_b   (rd_data_b),
        .i_operand_reg (5'(r_rsel)),
        .i_data_base   (r_data_base),
        .i_const_base  (r_const_base),
        .i_big_endian  (r_big_endian),
        .o_rsp         (calc_rsp)
    );

    // Write-back in the calculation cycle: a register load or a base update.
    always_comb begin
        wr_en   = r_busy && ((r_req.action == ACT_WRITE) || calc_rsp.base_updated);
        wr_idx  = ((r_req.action == ACT_WRITE) || (r_req.mode == MODE_IND_OFF_UPD))
                  ? r_rsel : r_bidx;
        wr_data = (r_req.action == ACT_WRITE) ? r_req.write_value : calc_rsp.address;
    end

    // Request capture; the payload needs no reset.
    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_req.action       <= i_req.action;
            r_req.mode         <= i_req.mode;
            r_req.reg_sel      <= i_req.reg_sel;
            r_req.ext_word     <= i_req.ext_word;
            r_req.inst_addr    <= i_req.inst_addr;
            r_req.operand_size <= i_req.operand_size;
            r_req.write_value  <= i_req.write_value;
            r_rsel             <= in_rsel;
            r_bidx             <= in_bidx;
        end
        if (r_busy) begin
            r_rsp <= calc_rsp;
        end
    end

    // Item sequencing and output register valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (acc) begin
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_busy <= 1'b0;
            end
            if (r_busy) begin
                r_out_vld <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // Configuration registers; unknown indexes are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_data_base  <= 32'd0;
            r_const_base <= 32'd0;
            r_big_endian <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_DATA_BASE:  r_data_base  <= i_cfg_wdata;
                CFG_CONST_BASE: r_const_base <= i_cfg_wdata;
                CFG_BIG_ENDIAN: r_big_endian <= i_cfg_wdata[0];
                default:        ;
            endcase
        end
    end

    // Output channel.
    assign o_rsp.valid          = r_out_vld;
    assign o_rsp.result_kind    = r_rsp.result_kind;
    assign o_rsp.address        = r_rsp.address;
    assign o_rsp.operand_reg    = r_rsp.operand_reg;
    assign o_rsp.next_inst_addr = r_rsp.next_inst_addr;
    assign o_rsp.base_updated   = r_rsp.base_updated;

`ifndef SYNTH
    // An accepted item always finds the output register empty next cycle.
    a_accept_to_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc |=> (r_busy && !r_out_vld))
        else $error("accepted item did not start calculation on an empty output");

    // Calculation clears busy in the next cycle and always delivers a result.
    a_busy_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |=> (r_out_vld && !r_busy))
        else $error("calculation cycle did not load the output register");

    // A base write-back only happens for a memory operand.
    a_upd_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_rsp.base_updated) |-> (r_rsp.result_kind == KIND_MEM))
        else $error("base update reported for a non-memory result");

    // A register file write always follows the acceptance of its own item.
    a_wr_after_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |-> $past(acc))
        else $error("register file written without a preceding transfer");
`endif

endmodule

// ----- tb/testbench.sv -----
// Self-checking testbench for the effective address unit of the virtual machine.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import vmea_pkg::*;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_idx;
    logic [31:0] cfg_wdata;

    vmea_req_if req_bus ();
    vmea_rsp_if rsp_bus ();

    vm_effective_address_unit_core u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (req_bus),
        .o_rsp       (rsp_bus),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_wdata (cfg_wdata)
    );

    // Predictor state: register file and section bases as the unit should hold them.
    logic [31:0] vm_regs [32];
    logic [31:0] data_base_q;
    logic [31:0] const_base_q;
    logic        big_endian_q;

    // Expected results in acceptance order, and the failure count.
    t_ea_rsp     expected_ea_q [$];
    int          mismatch_count = 0;

    // Pacing controls shared by the sender, the receiver and the tests.
    bit          pace_tight = 1'b0;
    int          rsp_hold_cycles = 0;
    bit          rsp_hold_active = 1'b0;

    // Clock with a 2 ns period.
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Run limit, far above the slowest correct run.
    initial begin
        #2000000;
        $display("Test completed with failures");
        $finish;
    end

    // Computes the result of one input item and updates the predicted state.
    function automatic t_ea_rsp compute_effective_address(input t_ea_req item);
        t_ea_rsp     rsp;
        logic [4:0]  base_sel;
        logic [4:0]  index_sel;
        logic [31:0] index_term;
        logic [31:0] after_ext;
        logic [2:0]  lit_size;
        rsp = '0;
        rsp.result_kind = KIND_MEM;
        rsp.next_inst_addr = item.inst_addr;
        base_sel = item.ext_word[4:0];
        index_sel = item.ext_word[12:8];
        after_ext = item.inst_addr + WORD_BYTES;

        if (item.action == ACT_WRITE) begin
            vm_regs[item.reg_sel] = item.write_value;
            rsp.result_kind = KIND_WRITE;
            rsp.next_inst_addr = '0;
            return rsp;
        end

        case (item.mode)
            MODE_DIRECT: begin
                rsp.result_kind = KIND_REG;
                rsp.operand_reg = item.reg_sel;
            end
            MODE_IND: begin
                rsp.address = vm_regs[item.reg_sel];
            end
            MODE_IND_OFF, MODE_IND_OFF_UPD: begin
                rsp.address = vm_regs[item.reg_sel] + item.ext_word;
                rsp.next_inst_addr = after_ext;
                if (item.mode == MODE_IND_OFF_UPD) begin
                    vm_regs[item.reg_sel] = rsp.address;
                    rsp.base_updated = 1'b1;
                end
            end
            MODE_IDX, MODE_IDX_UPD, MODE_SCALED, MODE_SCALED_UPD: begin
                // Only the low 32 bits of the product matter after the wrap.
                index_term = vm_regs[index_sel];
                if (item.mode == MODE_SCALED || item.mode == MODE_SCALED_UPD) begin
                    index_term = index_term * {16'd0, item.ext_word[31:16]};
                end
                rsp.address = vm_regs[base_sel] + index_term;
                rsp.next_inst_addr = after_ext;
                if (item.mode == MODE_IDX_UPD || item.mode == MODE_SCALED_UPD) begin
                    vm_regs[base_sel] = rsp.address;
                    rsp.base_updated = 1'b1;
                end
            end
            MODE_CTR: begin
                rsp.result_kind = KIND_CTR;
            end
            MODE_DATA: begin
                rsp.address = data_base_q + item.ext_word;
                rsp.next_inst_addr = after_ext;
            end
            MODE_CONST: begin
                rsp.address = const_base_q + item.ext_word;
                rsp.next_inst_addr = after_ext;
            end
            MODE_LIT: begin
                // A size of zero or beyond one word counts as a full word.
                lit_size = item.operand_size;
                if (lit_size == 3'd0 || lit_size > WORD_SIZE) begin
                    lit_size = WORD_SIZE;
                end
                rsp.address = after_ext;
                if (big_endian_q) begin
                    rsp.address = after_ext + (WORD_BYTES - {29'd0, lit_size});
                end
                rsp.next_inst_addr = after_ext;
            end
            MODE_PC: begin
                rsp.address = after_ext + (item.ext_word << 2);
                rsp.next_inst_addr = after_ext;
            end
            default: begin
                // Spare mode codes answer a null memory address.
                rsp.address = '0;
            end
        endcase
        return rsp;
    endfunction

    // Idle length for either side: mostly none or short, now and then long.
    function automatic int idle_span();
        int roll;
        if (pace_tight) begin
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 50) begin
            return 0;
        end
        if (roll < 85) begin
            return $urandom_range(1, 2);
        end
        if (roll < 97) begin
            return $urandom_range(3, 8);
        end
        return $urandom_range(20, 60);
    endfunction

    // One of the boundary words that stress wrap-around and sign handling.
    function automatic logic [31:0] extreme_word();
        case ($urandom_range(0, 3))
            0: return 32'h0000_0000;
            1: return 32'hFFFF_FFFF;
            2: return 32'h8000_0000;
            default: return 32'h7FFF_FFFF;
        endcase
    endfunction

    function automatic t_ea_req make_write(input logic [4:0] sel, input logic [31:0] value);
        t_ea_req item;
        item = '0;
        item.action = ACT_WRITE;
        item.reg_sel = sel;
        item.write_value = value;
        return item;
    endfunction

    function automatic t_ea_req make_eval(input logic [3:0] mode, input logic [4:0] sel,
                                          input logic [31:0] ext, input logic [31:0] inst,
                                          input logic [2:0] size);
        t_ea_req item;
        item = '0;
        item.action = ACT_EVAL;
        item.mode = mode;
        item.reg_sel = sel;
        item.ext_word = ext;
        item.inst_addr = inst;
        item.operand_size = size;
        item.write_value = $urandom;
        return item;
    endfunction

    // Random item: mostly evaluations over the defined modes, some writes.
    function automatic t_ea_req random_request();
        t_ea_req item;
        int      pick;
        item.action = ($urandom_range(0, 3) == 0) ? ACT_WRITE : ACT_EVAL;
        if ($urandom_range(0, 19) < 18) begin
            item.mode = 4'($urandom_range(int'(MODE_DIRECT), int'(MODE_PC)));
        end else begin
            item.mode = 4'($urandom);
        end
        item.reg_sel = 5'($urandom);

        pick = $urandom_range(0, 9);
        if (pick < 3) begin
            item.ext_word = $urandom;
        end else if (pick < 5) begin
            item.ext_word = 32'(int'($urandom_range(0, 64)) - 32);
        end else if (pick < 9) begin
            item.ext_word[7:0] = 8'($urandom);
            item.ext_word[15:8] = 8'($urandom);
            item.ext_word[31:16] = ($urandom_range(0, 1) == 0) ?
                                   16'($urandom_range(0, 8)) : 16'($urandom);
        end else begin
            item.ext_word = extreme_word();
        end

        pick = $urandom_range(0, 9);
        if (pick < 8) begin
            item.inst_addr = {30'($urandom), 2'b00};
        end else if (pick < 9) begin
            item.inst_addr = $urandom;
        end else begin
            item.inst_addr = extreme_word();
        end

        item.operand_size = 3'($urandom_range(0, 7));
        item.write_value = ($urandom_range(0, 3) == 0) ? extreme_word() : 32'($urandom);
        return item;
    endfunction

    // Offers one item, records its expected result once the transfer happens.
    task automatic send_request(input t_ea_req item);
        int gap;
        gap = idle_span();
        if (gap > 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_bus.valid        <= 1'b1;
        req_bus.action       <= item.action;
        req_bus.mode         <= item.mode;
        req_bus.reg_sel      <= item.reg_sel;
        req_bus.ext_word     <= item.ext_word;
        req_bus.inst_addr    <= item.inst_addr;
        req_bus.operand_size <= item.operand_size;
        req_bus.write_value  <= item.write_value;
        do @(posedge i_clk); while (!req_bus.ready);
        expected_ea_q.push_back(compute_effective_address(item));
    endtask

    // Stops offering and waits until every expected result has come back.
    task automatic wait_drained();
        req_bus.valid <= 1'b0;
        while (expected_ea_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_cfg(input logic [1:0] idx, input logic [31:0] value);
        cfg_we    <= 1'b1;
        cfg_idx   <= idx;
        cfg_wdata <= value;
        @(posedge i_clk);
    endtask

    // Writes all three configuration registers; the unit must be idle.
    task automatic set_config(input logic [31:0] db, input logic [31:0] cb, input logic be);
        write_cfg(CFG_DATA_BASE, db);
        write_cfg(CFG_CONST_BASE, cb);
        write_cfg(CFG_BIG_ENDIAN, {31'd0, be});
        cfg_we <= 1'b0;
        data_base_q  = db;
        const_base_q = cb;
        big_endian_q = be;
    endtask

    // Field extremes, every mode and each corner case of the address rules.
    task automatic test_directed_modes();
        int m;
        set_config(32'hFFFF_FFFF, 32'h8000_0000, 1'b1);
        send_request(make_write(5'd0, 32'hFFFF_FFFF));
        send_request(make_write(5'd31, 32'h8000_0000));
        send_request(make_write(5'd5, 32'h0000_0010));
        send_request(make_eval(MODE_DIRECT, 5'd31, 32'h0, 32'h0000_1000, 3'd4));
        send_request(make_eval(MODE_IND, 5'd31, 32'h0, 32'h0000_1000, 3'd4));
        send_request(make_eval(MODE_IND_OFF, 5'd5, 32'hFFFF_FFF0, 32'h0000_1000, 3'd4));
        // Base update that wraps the register to zero, then read it back.
        send_request(make_eval(MODE_IND_OFF_UPD, 5'd0, 32'h0000_0001, 32'h0, 3'd4));
        send_request(make_eval(MODE_IND, 5'd0, 32'h0, 32'h0, 3'd4));
        // Extension bytes beyond the register count fold back into range.
        send_request(make_eval(MODE_IDX, 5'd0, 32'h0000_FFE5, 32'h0, 3'd4));
        // Base and index on the same register with write-back.
        send_request(make_eval(MODE_IDX_UPD, 5'd0, 32'h0000_0505, 32'h0, 3'd4));
        send_request(make_eval(MODE_SCALED, 5'd0, 32'hFFFF_1F05, 32'h0, 3'd4));
        send_request(make_eval(MODE_SCALED_UPD, 5'd0, 32'h0004_051F, 32'h0, 3'd4));
        send_request(make_eval(MODE_CTR, 5'd17, 32'hFFFF_FFFF, 32'hFFFF_FFFC, 3'd4));
        send_request(make_eval(MODE_DATA, 5'd0, 32'h7FFF_FFFF, 32'h0000_0040, 3'd4));
        send_request(make_eval(MODE_CONST, 5'd0, 32'h8000_0000, 32'h0000_0040, 3'd4));
        // Literal sizes, including the out-of-range ones.
        send_request(make_eval(MODE_LIT, 5'd0, 32'h0, 32'hFFFF_FFFC, 3'd0));
        send_request(make_eval(MODE_LIT, 5'd0, 32'h0, 32'hFFFF_FFFC, 3'd1));
        send_request(make_eval(MODE_LIT, 5'd0, 32'h0, 32'hFFFF_FFFC, 3'd4));
        send_request(make_eval(MODE_LIT, 5'd0, 32'h0, 32'hFFFF_FFFC, 3'd5));
        send_request(make_eval(MODE_LIT, 5'd0, 32'h0, 32'hFFFF_FFFC, 3'd7));
        send_request(make_eval(MODE_PC, 5'd0, 32'h8000_0000, 32'hFFFF_FFFC, 3'd4));
        send_request(make_eval(MODE_PC, 5'd0, 32'hFFFF_FFFF, 32'h0, 3'd4));
        // Spare mode codes above the last defined one.
        for (m = int'(MODE_PC) + 1; m < (1 << $bits(t_mode)); m++) begin
            send_request(make_eval(4'(m), 5'd3, 32'h1234_5678, 32'h0000_2000, 3'd2));
        end
        wait_drained();
    endtask

    task automatic test_random_traffic(input int count, input bit tight);
        int n;
        pace_tight = tight;
        for (n = 0; n < count; n++) begin
            send_request(random_request());
        end
        wait_drained();
        pace_tight = 1'b0;
    endtask

    // The receiver holds off while items keep coming, so the input stalls.
    task automatic test_output_stall();
        int n;
        rsp_hold_cycles = 200;
        while (!rsp_hold_active) @(posedge i_clk);
        for (n = 0; n < 60; n++) begin
            send_request(random_request());
        end
        wait_drained();
    endtask

    // The sender pauses mid-stream until the unit has emptied.
    task automatic test_drain_pause();
        int n;
        for (n = 0; n < 40; n++) begin
            send_request(random_request());
        end
        wait_drained();
        for (n = 0; n < 40; n++) begin
            send_request(random_request());
        end
        wait_drained();
    endtask

    // Receiver pacing, including the long counted hold-off.
    initial begin : rsp_pacing
        int span;
        rsp_bus.ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (rsp_hold_cycles > 0) begin
                span = rsp_hold_cycles;
                rsp_hold_cycles = 0;
                rsp_hold_active = 1'b1;
                rsp_bus.ready <= 1'b0;
                repeat (span) @(posedge i_clk);
                rsp_hold_active = 1'b0;
            end else begin
                span = idle_span();
                if (span > 0) begin
                    rsp_bus.ready <= 1'b0;
                    repeat (span) @(posedge i_clk);
                end
                rsp_bus.ready <= 1'b1;
                repeat ($urandom_range(1, 8)) @(posedge i_clk);
            end
        end
    end

    function automatic void report_mismatch(input string field, input logic [31:0] want,
                                            input logic [31:0] got);
        mismatch_count++;
        if (mismatch_count <= 10) begin
            $display("Mismatch on %s: expected %h, got %h", field, want, got);
        end
    endfunction

    // Compares each result transfer with the oldest expectation.
    always @(posedge i_clk) begin
        t_ea_rsp want;
        if (i_rst_n && rsp_bus.valid && rsp_bus.ready) begin
            if (expected_ea_q.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10) begin
                    $display("Result transfer with nothing pending: kind %0d address %h",
                             rsp_bus.result_kind, rsp_bus.address);
                end
            end else begin
                want = expected_ea_q.pop_front();
                if (rsp_bus.result_kind !== want.result_kind) begin
                    report_mismatch("result_kind", 32'(want.result_kind),
                                    32'(rsp_bus.result_kind));
                end
                if (rsp_bus.address !== want.address) begin
                    report_mismatch("address", want.address, rsp_bus.address);
                end
                if (rsp_bus.operand_reg !== want.operand_reg) begin
                    report_mismatch("operand_reg", 32'(want.operand_reg),
                                    32'(rsp_bus.operand_reg));
                end
                if (rsp_bus.next_inst_addr !== want.next_inst_addr) begin
                    report_mismatch("next_inst_addr", want.next_inst_addr,
                                    rsp_bus.next_inst_addr);
                end
                if (rsp_bus.base_updated !== want.base_updated) begin
                    report_mismatch("base_updated", 32'(want.base_updated),
                                    32'(rsp_bus.base_updated));
                end
            end
        end
    end

    // Reset, then the tests in turn, then the verdict.
    initial begin
        i_rst_n              <= 1'b0;
        cfg_we               <= 1'b0;
        cfg_idx              <= CFG_DATA_BASE;
        cfg_wdata            <= '0;
        req_bus.valid        <= 1'b0;
        req_bus.action       <= ACT_WRITE;
        req_bus.mode         <= MODE_DIRECT;
        req_bus.reg_sel      <= '0;
        req_bus.ext_word     <= '0;
        req_bus.inst_addr    <= '0;
        req_bus.operand_size <= '0;
        req_bus.write_value  <= '0;
        foreach (vm_regs[r]) vm_regs[r] = '0;
        data_base_q  = '0;
        const_base_q = '0;
        big_endian_q = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_modes();
        set_config(32'h0000_0000, 32'h0000_0000, 1'b0);
        test_random_traffic(400, 1'b0);
        set_config($urandom, $urandom, 1'b1);
        test_random_traffic(350, 1'b1);
        test_output_stall();
        test_drain_pause();
        set_config(32'h8000_0000, 32'hFFFF_FFFF, 1'b0);
        test_random_traffic(450, 1'b0);

        wait_drained();
        repeat (8) @(posedge i_clk);
        if (mismatch_count == 0 && expected_ea_q.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
